// ===== hw/rtl/edhc_pkg.sv =====
// ----------------------------------------------------------------------------
// edhc_pkg
// Shared types and constants for the clipped scaled distance block.
// ----------------------------------------------------------------------------
package edhc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 1024;

    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int SUM_BITS  = 48;
    localparam int ACC_BITS  = ((SQ_BITS > SUM_BITS) ? SQ_BITS : SUM_BITS) + 1;
    localparam int CNT_BITS  = $clog2(MAX_LEN + 2);

    localparam int SCALE_BITS = 16;
    localparam int DIST_BITS  = 32;
    localparam int CFG_BITS   = 32;

    // root of (sum << 16): 64-bit radicand, 32-bit root
    localparam int RAD_BITS   = 2 * DIST_BITS;
    localparam int ROOT_BITS  = DIST_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int ITER_BITS  = $clog2(ROOT_BITS);
    localparam int PROD_BITS  = ROOT_BITS + SCALE_BITS;
    localparam int FRAC_BITS  = 8;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(256);
    localparam logic [DIST_BITS-1:0]  MAXD_RESET  = {DIST_BITS{1'b1}};

    // register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_MAXD  = 1'b1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROOT,
        BK_MUL,
        BK_DONE
    } t_bk_state;

    // one finished sum of squares moving through the queue
    typedef struct packed {
        logic                vld;
        logic [SUM_BITS-1:0] sum;
    } t_sum_xfer;

endpackage

// ===== hw/rtl/euclidean_distance_hard_clipped.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_hard_clipped
// Streaming clipped, scaled distance between two signed integer vectors.
// ----------------------------------------------------------------------------
// One element pair is taken per cycle while o_in_stall is low; the front end
// squares the difference and adds it into a 48-bit saturating sum (held at full
// scale once a vector runs past MAX_LEN pairs). The pair marked last closes the
// vector: its sum goes into a two-entry queue, and the result o_distance
// (unsigned Q24.8, min(max_distance, (floor(sqrt(sum) * 256) * scale) >> 8))
// follows the square root, produced one bit per cycle. The back end takes a new
// sum only once its last result is registered, so short vectors can fill the
// queue and stall the input. The user must write scale and max_distance through
// the cfg port only while no vector is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module euclidean_distance_hard_clipped (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [edhc_pkg::SAMPLE_BITS-1:0] i_elem_a,
    input  logic signed [edhc_pkg::SAMPLE_BITS-1:0] i_elem_b,
    input  logic                                  i_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [edhc_pkg::DIST_BITS-1:0]        o_distance,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [edhc_pkg::CFG_BITS-1:0]         i_cfg_data
);

    logic [edhc_pkg::SCALE_BITS-1:0] r_scale;
    logic [edhc_pkg::DIST_BITS-1:0]  r_max_dist;

    edhc_pkg::t_sum_xfer w_push;
    edhc_pkg::t_sum_xfer w_head;
    logic                w_full;
    logic                w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= edhc_pkg::SCALE_RESET;
            r_max_dist <= edhc_pkg::MAXD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                edhc_pkg::CFG_SCALE: r_scale    <= i_cfg_data[edhc_pkg::SCALE_BITS-1:0];
                edhc_pkg::CFG_MAXD:  r_max_dist <= i_cfg_data[edhc_pkg::DIST_BITS-1:0];
                default: begin
                    r_scale    <= r_scale;
                    r_max_dist <= r_max_dist;
                end
            endcase
        end
    end

    edhc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_elem_a   (i_elem_a),
        .i_elem_b   (i_elem_b),
        .i_last     (i_last),
        .o_push     (w_push),
        .i_full     (w_full)
    );

    edhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    edhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_scale     (r_scale),
        .i_max_dist  (r_max_dist),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance)
    );

    // a finished sum is never dropped on a full queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |-> !w_full)
        else $error("sum pushed into full queue");

    // the root unit only takes a sum that is there
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.vld)
        else $error("pop from empty queue");

    // every delivered distance respects the cap
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_distance <= r_max_dist))
        else $error("distance above cap");

endmodule

// ===== hw/rtl/edhc_front.sv =====
// ----------------------------------------------------------------------------
// edhc_front
// Element front end: difference, square and saturating accumulation.
// ----------------------------------------------------------------------------
module edhc_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [edhc_pkg::SAMPLE_BITS-1:0] i_elem_a,
    input  logic signed [edhc_pkg::SAMPLE_BITS-1:0] i_elem_b,
    input  logic                                  i_last,
    output edhc_pkg::t_sum_xfer                   o_push,
    input  logic                                  i_full
);

    localparam int SB = edhc_pkg::SAMPLE_BITS;
    localparam logic [edhc_pkg::SUM_BITS-1:0] SUM_FULL = {edhc_pkg::SUM_BITS{1'b1}};

    logic                           w_adv;
    logic signed [SB:0]             w_diff;
    logic        [SB:0]             w_abs;

    logic                           r_a_vld;
    logic                           r_a_last;
    logic [SB-1:0]                  r_a_mag;
    logic                           r_b_vld;
    logic                           r_b_last;
    logic [edhc_pkg::SQ_BITS-1:0]   r_b_sq;
    logic [edhc_pkg::SUM_BITS-1:0]  r_sum;
    logic [edhc_pkg::CNT_BITS-1:0]  r_cnt;

    logic [edhc_pkg::CNT_BITS-1:0]  n_cnt;
    logic [edhc_pkg::SUM_BITS-1:0]  n_sum;
    logic [edhc_pkg::ACC_BITS-1:0]  w_acc;

    // pipeline freezes only while a finished sum cannot enter the queue
    assign w_adv      = !(r_b_vld && r_b_last && i_full);
    assign o_in_stall = !w_adv;

    assign w_diff = {i_elem_a[SB-1], i_elem_a} - {i_elem_b[SB-1], i_elem_b};
    assign w_abs  = w_diff[SB] ? (SB+1)'(-w_diff) : w_diff;

    always_comb begin
        n_cnt = r_cnt;
        if (r_cnt <= edhc_pkg::CNT_BITS'(edhc_pkg::MAX_LEN)) begin
            n_cnt = r_cnt + 1'b1;
        end
        w_acc = edhc_pkg::ACC_BITS'(r_sum) + edhc_pkg::ACC_BITS'(r_b_sq);
        if (n_cnt > edhc_pkg::CNT_BITS'(edhc_pkg::MAX_LEN)) begin
            n_sum = SUM_FULL;
        end else if (w_acc > edhc_pkg::ACC_BITS'(SUM_FULL)) begin
            n_sum = SUM_FULL;
        end else begin
            n_sum = w_acc[edhc_pkg::SUM_BITS-1:0];
        end
    end

    assign o_push.vld = r_b_vld && r_b_last && !i_full;
    assign o_push.sum = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else if (w_adv) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            if (r_b_vld) begin
                if (r_b_last) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_last <= i_last;
            r_a_mag  <= w_abs[SB-1:0];
            r_b_last <= r_a_last;
            r_b_sq   <= edhc_pkg::SQ_BITS'(r_a_mag) * edhc_pkg::SQ_BITS'(r_a_mag);
        end
    end

endmodule

// ===== hw/rtl/edhc_queue.sv =====
// ----------------------------------------------------------------------------
// edhc_queue
// Two-entry queue of finished sums between front end and root unit.
// ----------------------------------------------------------------------------
module edhc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  edhc_pkg::t_sum_xfer i_push,
    output logic                o_full,
    output edhc_pkg::t_sum_xfer o_head,
    input  logic                i_pop
);

    logic [edhc_pkg::SUM_BITS-1:0] r_mem [2];
    logic                          r_wr_ptr;
    logic                          r_rd_ptr;
    logic [1:0]                    r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_head.vld = (r_count != 2'd0);
    assign o_head.sum = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.vld) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push.vld, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr_ptr] <= i_push.sum;
        end
    end

endmodule

// ===== hw/rtl/edhc_back.sv =====
// ----------------------------------------------------------------------------
// edhc_back
// Back end: bit-serial square root, scale multiply, clip, result register.
// ----------------------------------------------------------------------------
module edhc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  edhc_pkg::t_sum_xfer                  i_head,
    output logic                                 o_pop,
    input  logic [edhc_pkg::SCALE_BITS-1:0]      i_scale,
    input  logic [edhc_pkg::DIST_BITS-1:0]       i_max_dist,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [edhc_pkg::DIST_BITS-1:0]       o_distance
);

    localparam int RB = edhc_pkg::REM_BITS;

    edhc_pkg::t_bk_state r_state;
    edhc_pkg::t_bk_state n_state;

    logic [edhc_pkg::RAD_BITS-1:0]  r_x;
    logic [RB-1:0]                  r_rem;
    logic [edhc_pkg::ROOT_BITS-1:0] r_root;
    logic [edhc_pkg::ITER_BITS-1:0] r_iter;
    logic [edhc_pkg::PROD_BITS-1:0] r_prod;
    logic                           r_out_valid;
    logic [edhc_pkg::DIST_BITS-1:0] r_out_dist;

    logic                           w_out_free;
    logic                           w_load;
    logic                           w_last_iter;
    logic [RB+1:0]                  w_rem_sh;
    logic [RB+1:0]                  w_trial;
    logic                           w_ge;
    logic [edhc_pkg::PROD_BITS-edhc_pkg::FRAC_BITS-1:0] w_scaled;
    logic [edhc_pkg::DIST_BITS-1:0] w_clip;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_iter = (r_iter == edhc_pkg::ITER_BITS'(edhc_pkg::ROOT_BITS - 1));

    // one root bit per cycle: bring down two radicand bits, try (root << 2) | 1
    assign w_rem_sh = {r_rem, r_x[edhc_pkg::RAD_BITS-1 -: 2]};
    assign w_trial  = (RB+2)'({r_root, 2'b01});
    assign w_ge     = (w_rem_sh >= w_trial);

    assign w_scaled = r_prod[edhc_pkg::PROD_BITS-1:edhc_pkg::FRAC_BITS];
    assign w_clip   = (w_scaled > (edhc_pkg::PROD_BITS-edhc_pkg::FRAC_BITS)'(i_max_dist))
                      ? i_max_dist : w_scaled[edhc_pkg::DIST_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            edhc_pkg::BK_IDLE: begin
                if (i_head.vld) begin
                    n_state = edhc_pkg::BK_ROOT;
                end
            end
            edhc_pkg::BK_ROOT: begin
                if (w_last_iter) begin
                    n_state = edhc_pkg::BK_MUL;
                end
            end
            edhc_pkg::BK_MUL: n_state = edhc_pkg::BK_DONE;
            edhc_pkg::BK_DONE: begin
                if (w_out_free) begin
                    n_state = edhc_pkg::BK_IDLE;
                end
            end
            default: n_state = edhc_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        case (r_state)
            edhc_pkg::BK_IDLE: o_pop  = i_head.vld;
            edhc_pkg::BK_DONE: w_load = w_out_free;
            default: begin
                o_pop  = 1'b0;
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= edhc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x    <= {i_head.sum, {(edhc_pkg::RAD_BITS-edhc_pkg::SUM_BITS){1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
            r_iter <= '0;
        end else if (r_state == edhc_pkg::BK_ROOT) begin
            r_x    <= {r_x[edhc_pkg::RAD_BITS-3:0], 2'b00};
            r_iter <= r_iter + 1'b1;
            if (w_ge) begin
                r_rem  <= RB'(w_rem_sh - w_trial);
                r_root <= {r_root[edhc_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= RB'(w_rem_sh);
                r_root <= {r_root[edhc_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
        if (r_state == edhc_pkg::BK_MUL) begin
            r_prod <= edhc_pkg::PROD_BITS'(r_root) * edhc_pkg::PROD_BITS'(i_scale);
        end
        if (w_load) begin
            r_out_dist <= w_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;

endmodule

// ===== sim/edhc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edhc_checker
// Watches the element, result and register ports of the distance block,
// keeps its own sum of squares and register copies, and checks every
// returned distance against the oldest predicted one.
// ----------------------------------------------------------------------------
module edhc_checker
    import edhc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_elem_a,
    input  logic signed [SAMPLE_BITS-1:0] i_elem_b,
    input  logic                          i_last,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [DIST_BITS-1:0]          i_distance,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [CFG_BITS-1:0]           i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    localparam logic [SUM_BITS-1:0] SUM_FULL = '1;

    logic [SCALE_BITS-1:0] scale_r;
    logic [DIST_BITS-1:0]  maxd_r;
    logic [SUM_BITS-1:0]   sq_sum;
    int unsigned           pair_cnt;
    logic [DIST_BITS-1:0]  dist_q[$];
    logic [DIST_BITS-1:0]  want;
    int                    err_cnt = 0;

    assign o_errors = err_cnt;

    task automatic report(input string msg);
        $display("edhc_checker: %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // floor(sqrt(x)), one result bit at a time from the top
    function automatic logic [ROOT_BITS-1:0] isqrt(input logic [RAD_BITS-1:0] x);
        logic [ROOT_BITS-1:0] r;
        logic [ROOT_BITS-1:0] t;
        r = '0;
        for (int i = ROOT_BITS - 1; i >= 0; i--) begin
            t = r | (ROOT_BITS'(1) << i);
            if (RAD_BITS'(t) * RAD_BITS'(t) <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [DIST_BITS-1:0] clipped_distance(input logic [SUM_BITS-1:0] s);
        logic [ROOT_BITS-1:0] root;
        logic [PROD_BITS-1:0] scaled;
        root   = isqrt({s, 16'h0000});
        scaled = (PROD_BITS'(root) * PROD_BITS'(scale_r)) >> FRAC_BITS;
        return (scaled > PROD_BITS'(maxd_r)) ? maxd_r : scaled[DIST_BITS-1:0];
    endfunction

    task automatic take_pair(input logic signed [SAMPLE_BITS-1:0] a,
                             input logic signed [SAMPLE_BITS-1:0] b,
                             input logic lst);
        logic signed [SAMPLE_BITS:0] diff;
        logic [SAMPLE_BITS:0]        mag;
        logic [SUM_BITS:0]           sq;
        logic [SUM_BITS:0]           total;
        diff = a - b;
        mag  = diff[SAMPLE_BITS] ? -diff : diff;
        sq   = (SUM_BITS+1)'(mag) * (SUM_BITS+1)'(mag);
        if (pair_cnt <= MAX_LEN)
            pair_cnt++;
        // an over-long vector pins the sum at full scale until its last pair
        if (pair_cnt > MAX_LEN) begin
            sq_sum = SUM_FULL;
        end else begin
            total  = {1'b0, sq_sum} + sq;
            sq_sum = total[SUM_BITS] ? SUM_FULL : total[SUM_BITS-1:0];
        end
        if (lst) begin
            dist_q.push_back(clipped_distance(sq_sum));
            sq_sum   = '0;
            pair_cnt = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scale_r  = SCALE_RESET;
            maxd_r   = MAXD_RESET;
            sq_sum   = '0;
            pair_cnt = 0;
            dist_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (dist_q.size() == 0) begin
                    report($sformatf("distance %08h with none outstanding", i_distance));
                end else begin
                    want = dist_q.pop_front();
                    if (i_distance !== want)
                        report($sformatf("distance %08h, predicted %08h", i_distance, want));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SCALE)
                    scale_r = i_cfg_data[SCALE_BITS-1:0];
                else if (i_cfg_idx == CFG_MAXD)
                    maxd_r = i_cfg_data[DIST_BITS-1:0];
            end
            if (i_in_valid && !i_in_stall)
                take_pair(i_elem_a, i_elem_b, i_last);
        end
        o_pending <= dist_q.size();
    end

endmodule

// ===== sim/euclidean_distance_hard_clipped_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euclidean_distance_hard_clipped_tb
// Streams signed element pairs into the clipped distance block under random
// gaps and stalls, across several scale and cap settings, and leaves the
// checking to edhc_checker.
// ----------------------------------------------------------------------------
module euclidean_distance_hard_clipped_tb;
    import edhc_pkg::*;

    localparam int N_PHASES       = 10;
    localparam int PHASE_ITEMS    = 25;
    localparam int PRESSURE_PHASE = 3;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_elem_a;
    logic signed [SAMPLE_BITS-1:0] i_elem_b;
    logic                          i_last;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [DIST_BITS-1:0]          o_distance;
    logic                          i_cfg_we;
    logic                          i_cfg_idx;
    logic [CFG_BITS-1:0]           i_cfg_data;

    int   errors;
    int   pending;
    int   sent_items = 0;
    int   idle_cycles = 0;
    logic hold_req = 1'b0;
    logic rx_quiet = 1'b0;
    logic tx_quiet = 1'b0;

    euclidean_distance_hard_clipped i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    edhc_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .i_last      (i_last),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_distance  (o_distance),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 4))
                0: return S_MIN;
                1: return S_MAX;
                2: return '0;
                3: return '1;
                default: return SAMPLE_BITS'(1);
            endcase
        end
        if (r < 30)
            return SAMPLE_BITS'($urandom_range(0, 16) - 8);
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    // called at a clock edge; returns at the edge of the transfer
    task automatic push_pair(input logic signed [SAMPLE_BITS-1:0] a,
                             input logic signed [SAMPLE_BITS-1:0] b,
                             input logic lst);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_elem_a   <= a;
        i_elem_b   <= b;
        i_last     <= lst;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sent_items++;
    endtask

    task automatic send_vector(input int len);
        logic signed [SAMPLE_BITS-1:0] a;
        logic signed [SAMPLE_BITS-1:0] b;
        for (int k = 0; k < len; k++) begin
            a = pick_elem();
            b = ($urandom_range(0, 9) == 0) ? a : pick_elem();
            push_pair(a, b, k == len - 1);
        end
    endtask

    // drop valid, let every outstanding distance come back, then let the
    // back end go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [SCALE_BITS-1:0] scl, input logic [DIST_BITS-1:0] maxd);
        write_cfg(CFG_SCALE, CFG_BITS'(scl));
        write_cfg(CFG_MAXD, CFG_BITS'(maxd));
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int len;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req    <= 1'b0;
                i_out_stall <= 1'b1;
                len = HOLD_CYCLES;
            end else if (!rx_quiet && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                len = pick_gap();
                if (len == 0)
                    len = 1;
            end else begin
                i_out_stall <= 1'b0;
                len = $urandom_range(1, 8);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("euclidean_distance_hard_clipped_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [SCALE_BITS-1:0] scl;
        logic [DIST_BITS-1:0]  maxd;
        int                    target;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_elem_a   = '0;
        i_elem_b   = '0;
        i_last     = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_SCALE;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        push_pair(S_MAX, S_MIN, 1'b1);
        push_pair(S_MIN, S_MAX, 1'b1);
        push_pair('0, '0, 1'b1);
        push_pair(S_MIN, S_MIN, 1'b1);
        push_pair(SAMPLE_BITS'(5), -SAMPLE_BITS'(3), 1'b0);
        push_pair('1, SAMPLE_BITS'(1), 1'b0);
        push_pair(SAMPLE_BITS'(100), -SAMPLE_BITS'(100), 1'b1);
        push_pair(SAMPLE_BITS'(1), '0, 1'b1);
        push_pair('1, '0, 1'b0);
        push_pair(S_MAX, S_MAX, 1'b0);
        push_pair(S_MIN, '0, 1'b1);
        push_pair(S_MAX, '1, 1'b0);
        push_pair(S_MIN, SAMPLE_BITS'(1), 1'b1);

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0: set_regs('0, '1);
                1: set_regs('1, '1);
                2: set_regs(SCALE_BITS'(1), '0);
                3: set_regs('1, DIST_BITS'($urandom_range(0, 24'hFFFFFF)));
                4: set_regs(SCALE_BITS'(256), DIST_BITS'(1));
                default: begin
                    scl  = SCALE_BITS'($urandom_range(0, 65535));
                    maxd = ($urandom_range(0, 1) == 0) ? '1 : DIST_BITS'($urandom);
                    set_regs(scl, maxd);
                end
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            target = sent_items + PHASE_ITEMS;
            if (p == PRESSURE_PHASE) begin
                // short vectors back to back against a blocked result side
                tx_quiet = 1'b1;
                hold_req <= 1'b1;
                while (sent_items < target)
                    send_vector($urandom_range(1, 3));
            end else begin
                while (sent_items < target)
                    send_vector(pick_len());
            end
        end

        // a vector past the length limit, then a short one after it
        settle();
        set_regs(SCALE_BITS'(256), '1);
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
        send_vector(MAX_LEN + 1);
        send_vector(3);

        settle();
        if (errors == 0)
            $display("euclidean_distance_hard_clipped_tb: done, clean");
        else
            $display("euclidean_distance_hard_clipped_tb: done, errors");
        $finish;
    end

endmodule

// ===== euclidean_distance_hard_clipped.f =====
hw/rtl/edhc_pkg.sv
hw/rtl/edhc_front.sv
hw/rtl/edhc_queue.sv
hw/rtl/edhc_back.sv
hw/rtl/euclidean_distance_hard_clipped.sv
sim/edhc_checker.sv
sim/euclidean_distance_hard_clipped_tb.sv
